@@ rtl/qslerp_pkg.sv @@
package qslerp_pkg;

  // request queue between front and back
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // iteration counts
  localparam int STEPS    = 30;  // CORDIC micro-rotations
  localparam int SQ_STEPS = 31;  // square root, one result bit per stage
  localparam int DV_STEPS = 18;  // overflow check plus 17 quotient bits

  localparam logic [16:0]        T_ONE        = 17'd65536;
  localparam logic [14:0]        THRESH_RESET = 15'd32752;
  localparam logic signed [33:0] GAIN_INV     = 34'sd652032874;

  // back pipeline stage map
  localparam int S_P0  = 0;
  localparam int S_P1  = 1;
  localparam int S_SQ  = 2;
  localparam int S_CV  = S_SQ + SQ_STEPS;
  localparam int S_TH  = S_CV + STEPS;
  localparam int S_SN  = S_TH + 1;
  localparam int S_NP  = S_SN + STEPS;
  localparam int S_NS  = S_NP + 1;
  localparam int S_DV  = S_NS + 1;
  localparam int S_OUT = S_DV + DV_STEPS;
  localparam int NST   = S_OUT + 1;

  // arctan(2^-i), scale 2^30 rad
  localparam logic [29:0] ATAN_Q30 [STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

  typedef logic signed [15:0] q15_t;
  typedef logic signed [16:0] q15x_t;

  // classified request as queued between front and back
  typedef struct packed {
    q15_t  [3:0] s;
    q15x_t [3:0] e;
    logic  [16:0] t;
    logic         neg;
    logic         lin;
    logic  [29:0] c;
  } qent_t;

  // fields riding along the back pipeline
  typedef struct packed {
    q15_t  [3:0] s;
    q15x_t [3:0] e;
    logic  [16:0] t;
    logic         neg;
    logic         lin;
    logic  [29:0] c;
    q15_t  [3:0] lo;
    logic  [30:0] sn;
  } carry_t;

endpackage

@@ rtl/quaternion_slerp_core.sv @@
// Quaternion slerp: each request (start and end quaternion in Q1.15, fraction t in
// Q1.16) gives one result, in request order. One request per clock is sustained
// while the result side does not stall. The back pipeline includes 31 square-root
// stages, 30 CORDIC vectoring stages for theta, 30 CORDIC rotation stages for both
// sines and 18 divider stages, behind two front stages (dot product, sign fold, path
// choice) and an 8-entry request queue. full rises while the queue and front together
// hold 8 requests. linear_threshold is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module quaternion_slerp_core import qslerp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  q15_t        start_x,
  input  q15_t        start_y,
  input  q15_t        start_z,
  input  q15_t        start_w,
  input  q15_t        end_x,
  input  q15_t        end_y,
  input  q15_t        end_z,
  input  q15_t        end_w,
  input  logic [16:0] fraction,
  output logic        empty,
  input  logic        pop,
  output q15_t        out_x,
  output q15_t        out_y,
  output q15_t        out_z,
  output q15_t        out_w,
  output logic        used_linear,
  output logic        end_negated,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  logic           q_wr;
  qent_t          q_wdata;
  logic           q_rd;
  qent_t          q_rdata;
  logic           q_empty;
  logic [QCW-1:0] q_count;

  // classify requests
  qslerp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .start_x   (start_x),
    .start_y   (start_y),
    .start_z   (start_z),
    .start_w   (start_w),
    .end_x     (end_x),
    .end_y     (end_y),
    .end_z     (end_z),
    .end_w     (end_w),
    .fraction  (fraction),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  // decoupling queue
  qslerp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  // interpolation pipeline and result register
  qslerp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_rdata     (q_rdata),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_w       (out_w),
    .used_linear (used_linear),
    .end_negated (end_negated)
  );

endmodule

@@ rtl/qslerp_fifo.sv @@
module qslerp_fifo import qslerp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  qent_t          wdata,
  input  logic           rd,
  output qent_t          rdata,
  output logic           empty,
  output logic [QCW-1:0] count
);

  qent_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + QAW'(1);
      if (rd) rp <= rp + QAW'(1);
      count <= count + QCW'(wr) - QCW'(rd);
    end
  end

  assign rdata = mem[rp];
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && !rd && count == QCW'(QDEPTH)))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd && empty))
    else $error("request queue read while empty");

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("request queue level out of range");

endmodule

@@ rtl/qslerp_front.sv @@
module qslerp_front import qslerp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  q15_t           start_x,
  input  q15_t           start_y,
  input  q15_t           start_z,
  input  q15_t           start_w,
  input  q15_t           end_x,
  input  q15_t           end_y,
  input  q15_t           end_z,
  input  q15_t           end_w,
  input  logic [16:0]    fraction,
  input  logic           cfg_we,
  input  logic [14:0]    cfg_wdata,
  input  logic [QCW-1:0] q_count,
  output logic           q_wr,
  output qent_t          q_wdata
);

  logic [14:0]         thr;
  logic                accept;
  logic [QCW:0]        occ;
  q15_t                in_s [4];
  q15_t                in_e [4];
  logic                va;
  q15_t                sa [4];
  q15_t                ea [4];
  logic [16:0]         ta;
  logic signed [31:0]  pa [4];
  logic signed [33:0]  dot;
  logic signed [33:0]  dabs;
  logic                dneg;
  logic                dlin;
  q15x_t               en [4];
  logic                vb;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // admission: queue level plus requests still in the front stages
  assign occ    = (QCW+1)'(q_count) + (QCW+1)'(va) + (QCW+1)'(vb);
  assign full   = (occ >= (QCW+1)'(QDEPTH));
  assign accept = push && !full;

  assign in_s[0] = start_x;
  assign in_s[1] = start_y;
  assign in_s[2] = start_z;
  assign in_s[3] = start_w;
  assign in_e[0] = end_x;
  assign in_e[1] = end_y;
  assign in_e[2] = end_z;
  assign in_e[3] = end_w;

  // stage A: component products, clamped fraction
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= accept;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sa[k] <= in_s[k];
      ea[k] <= in_e[k];
      pa[k] <= in_s[k] * in_e[k];
    end
    ta <= (fraction > T_ONE) ? T_ONE : fraction;
  end

  // dot sum, sign fold, path choice
  always_comb begin
    dot  = 34'(pa[0]) + 34'(pa[1]) + 34'(pa[2]) + 34'(pa[3]);
    dneg = dot[33];
    dabs = dneg ? -dot : dot;
    dlin = dabs > $signed({4'b0, thr, 15'b0});
    for (int k = 0; k < 4; k++) begin
      en[k] = dneg ? -17'(ea[k]) : 17'(ea[k]);
    end
  end

  // stage B: classified request toward the queue
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      q_wdata.s[k] <= sa[k];
      q_wdata.e[k] <= en[k];
    end
    q_wdata.t   <= ta;
    q_wdata.neg <= dneg;
    q_wdata.lin <= dlin;
    q_wdata.c   <= dabs[29:0];
  end

  assign q_wr = vb;

  a_room: assert property (@(posedge clk) disable iff (rst)
    occ <= (QCW+1)'(QDEPTH))
    else $error("front admitted more requests than the queue holds");

endmodule

@@ rtl/qslerp_back.sv @@
module qslerp_back import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  qent_t q_rdata,
  input  logic  q_empty,
  output logic  q_rd,
  output logic  empty,
  input  logic  pop,
  output q15_t  out_x,
  output q15_t  out_y,
  output q15_t  out_z,
  output q15_t  out_w,
  output logic  used_linear,
  output logic  end_negated
);

  localparam logic [60:0] ONE_Q60 = 61'd1 << 60;

  logic [NST-1:0] vld;
  logic           adv;
  carry_t         cry [NST];
  logic [16:0]    tm0;

  // whole pipeline moves unless the output register is held
  assign adv  = !vld[NST-1] || pop;
  assign q_rd = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], !q_empty};
    end
  end

  function automatic q15_t sat_lin(input logic signed [19:0] v);
    if (v > 20'sd32767)       return 16'sh7fff;
    else if (v < -20'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  // P0: square of the dot, linear blend products
  logic [59:0]        cc0;
  logic signed [35:0] ls0 [4];
  logic signed [35:0] le0 [4];

  assign tm0 = T_ONE - q_rdata.t;

  always_ff @(posedge clk) begin
    if (adv) begin
      cc0 <= 60'(q_rdata.c) * 60'(q_rdata.c);
      for (int k = 0; k < 4; k++) begin
        ls0[k] <= $signed(q_rdata.s[k]) * $signed({1'b0, tm0});
        le0[k] <= $signed(q_rdata.e[k]) * $signed({1'b0, q_rdata.t});
      end
    end
  end

  // P1: radicand, rounded and saturated linear result
  logic [60:0]        n1;
  logic signed [35:0] lsum [4];
  q15_t               lo_calc [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lsum[k]    = ls0[k] + le0[k] + 36'sd32768;
      lo_calc[k] = sat_lin(lsum[k][35:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1 <= ONE_Q60 - 61'(cc0);
    end
  end

  // SQ: integer square root, one result bit per stage
  logic [60:0] sqn [SQ_STEPS];
  logic [60:0] sqr [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam logic [60:0] BITV = 61'd1 << (60 - 2 * i);
    logic [60:0] n_in;
    logic [60:0] r_in;
    logic [61:0] trial;
    if (i == 0) begin : g_first
      assign n_in = n1;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = sqn[i-1];
      assign r_in = sqr[i-1];
    end
    assign trial = {1'b0, r_in} + {1'b0, BITV};
    always_ff @(posedge clk) begin
      if (adv) begin
        if ({1'b0, n_in} >= trial) begin
          sqn[i] <= n_in - trial[60:0];
          sqr[i] <= (r_in >> 1) + BITV;
        end else begin
          sqn[i] <= n_in;
          sqr[i] <= r_in >> 1;
        end
      end
    end
  end

  // CV: CORDIC vectoring gives theta = atan2(sine, dot)
  logic signed [33:0] cvx [STEPS];
  logic signed [33:0] cvy [STEPS];
  logic signed [32:0] cvz [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_cv
    localparam logic signed [32:0] AT = $signed({3'b0, ATAN_Q30[j]});
    logic signed [33:0] xi;
    logic signed [33:0] yi;
    logic signed [32:0] zi;
    if (j == 0) begin : g_first
      assign xi = $signed({4'b0, cry[S_CV-1].c});
      assign yi = $signed({3'b0, sqr[SQ_STEPS-1][30:0]});
      assign zi = '0;
    end else begin : g_next
      assign xi = cvx[j-1];
      assign yi = cvy[j-1];
      assign zi = cvz[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!yi[33]) begin
          cvx[j] <= xi + (yi >>> j);
          cvy[j] <= yi - (xi >>> j);
          cvz[j] <= zi + AT;
        end else begin
          cvx[j] <= xi - (yi >>> j);
          cvy[j] <= yi + (xi >>> j);
          cvz[j] <= zi - AT;
        end
      end
    end
  end

  // TH: split theta by the fraction
  logic [30:0] theta;
  logic [16:0] tm_th;
  logic [47:0] pa1;
  logic [47:0] pa0;
  logic [30:0] a_r [2];

  assign theta = cvz[STEPS-1][30:0];
  assign tm_th = T_ONE - cry[S_TH-1].t;
  assign pa1   = 48'(theta) * 48'(cry[S_TH-1].t);
  assign pa0   = 48'(theta) * 48'(tm_th);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0] <= pa0[46:16];
      a_r[1] <= pa1[46:16];
    end
  end

  // SN: two CORDIC rotation lanes, sin((1-t)theta) and sin(t theta)
  logic signed [33:0] rx [2][STEPS];
  logic signed [33:0] ry [2][STEPS];
  logic signed [32:0] rz [2][STEPS];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar j = 0; j < STEPS; j++) begin : g_sn
      localparam logic signed [32:0] AT = $signed({3'b0, ATAN_Q30[j]});
      logic signed [33:0] xi;
      logic signed [33:0] yi;
      logic signed [32:0] zi;
      if (j == 0) begin : g_first
        assign xi = GAIN_INV;
        assign yi = '0;
        assign zi = $signed({2'b0, a_r[l]});
      end else begin : g_next
        assign xi = rx[l][j-1];
        assign yi = ry[l][j-1];
        assign zi = rz[l][j-1];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zi[32]) begin
            rx[l][j] <= xi - (yi >>> j);
            ry[l][j] <= yi + (xi >>> j);
            rz[l][j] <= zi - AT;
          end else begin
            rx[l][j] <= xi + (yi >>> j);
            ry[l][j] <= yi - (xi >>> j);
            rz[l][j] <= zi + AT;
          end
        end
      end
    end
  end

  // NP: weighted components
  logic signed [31:0] w0;
  logic signed [31:0] w1;
  logic signed [49:0] pw0 [4];
  logic signed [49:0] pw1 [4];

  assign w0 = ry[0][STEPS-1][31:0];
  assign w1 = ry[1][STEPS-1][31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        pw0[k] <= $signed(cry[S_NP-1].s[k]) * w0;
        pw1[k] <= $signed(cry[S_NP-1].e[k]) * w1;
      end
    end
  end

  // NS: numerator magnitude plus half divisor for rounding
  logic signed [49:0] num [4];
  logic [49:0]        mag [4];
  logic [50:0]        dvd [4];
  logic               dsg [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num[k] = pw0[k] + pw1[k];
      mag[k] = num[k][49] ? 50'(-num[k]) : 50'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        dvd[k] <= {1'b0, mag[k]} + 51'(cry[S_NS-1].sn >> 1);
        dsg[k] <= num[k][49];
      end
    end
  end

  // DV: restoring division, overflow check then one quotient bit per stage
  logic [50:0] drem [4][DV_STEPS];
  logic [16:0] dq   [4][DV_STEPS];
  logic        dovf [4][DV_STEPS];
  logic        dneg [4][DV_STEPS];

  for (genvar k = 0; k < 4; k++) begin : g_dk
    for (genvar m = 0; m < DV_STEPS; m++) begin : g_dv
      localparam int JB = DV_STEPS - 1 - m;
      logic [50:0] ri;
      logic [16:0] qi;
      logic        oi;
      logic        ni;
      logic [50:0] dsh;
      if (m == 0) begin : g_first
        assign ri = dvd[k];
        assign qi = '0;
        assign oi = 1'b0;
        assign ni = dsg[k];
      end else begin : g_next
        assign ri = drem[k][m-1];
        assign qi = dq[k][m-1];
        assign oi = dovf[k][m-1];
        assign ni = dneg[k][m-1];
      end
      assign dsh = 51'(cry[S_DV+m-1].sn) << JB;
      always_ff @(posedge clk) begin
        if (adv) begin
          dneg[k][m] <= ni;
          if (ri >= dsh) begin
            drem[k][m] <= ri - dsh;
            if (m == 0) begin
              dovf[k][m] <= 1'b1;
              dq[k][m]   <= qi;
            end else begin
              dovf[k][m] <= oi;
              dq[k][m]   <= qi | (17'd1 << JB);
            end
          end else begin
            drem[k][m] <= ri;
            dovf[k][m] <= oi;
            dq[k][m]   <= qi;
          end
        end
      end
    end
  end

  // OUT: pick the path and saturate
  q15_t oq_next [4];
  q15_t oq      [4];
  logic [16:0] qf [4];
  logic        of [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qf[k] = dq[k][DV_STEPS-1];
      of[k] = dovf[k][DV_STEPS-1];
      if (cry[S_OUT-1].lin) begin
        oq_next[k] = cry[S_OUT-1].lo[k];
      end else if (dneg[k][DV_STEPS-1]) begin
        oq_next[k] = (of[k] || qf[k] > 17'd32768) ? 16'sh8000 : q15_t'(-qf[k]);
      end else begin
        oq_next[k] = (of[k] || qf[k] > 17'd32767) ? 16'sh7fff : q15_t'(qf[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        oq[k] <= oq_next[k];
      end
    end
  end

  // fields that ride along every stage
  for (genvar g = 0; g < NST; g++) begin : g_cry
    if (g == S_P0) begin : g_load
      always_ff @(posedge clk) begin
        if (adv) begin
          cry[g].s   <= q_rdata.s;
          cry[g].e   <= q_rdata.e;
          cry[g].t   <= q_rdata.t;
          cry[g].neg <= q_rdata.neg;
          cry[g].lin <= q_rdata.lin;
          cry[g].c   <= q_rdata.c;
          cry[g].lo  <= '0;
          cry[g].sn  <= '0;
        end
      end
    end else if (g == S_P1) begin : g_lo
      always_ff @(posedge clk) begin
        if (adv) begin
          cry[g].s   <= cry[g-1].s;
          cry[g].e   <= cry[g-1].e;
          cry[g].t   <= cry[g-1].t;
          cry[g].neg <= cry[g-1].neg;
          cry[g].lin <= cry[g-1].lin;
          cry[g].c   <= cry[g-1].c;
          cry[g].sn  <= cry[g-1].sn;
          cry[g].lo  <= {lo_calc[3], lo_calc[2], lo_calc[1], lo_calc[0]};
        end
      end
    end else if (g == S_CV) begin : g_sn
      always_ff @(posedge clk) begin
        if (adv) begin
          cry[g].s   <= cry[g-1].s;
          cry[g].e   <= cry[g-1].e;
          cry[g].t   <= cry[g-1].t;
          cry[g].neg <= cry[g-1].neg;
          cry[g].lin <= cry[g-1].lin;
          cry[g].c   <= cry[g-1].c;
          cry[g].lo  <= cry[g-1].lo;
          cry[g].sn  <= sqr[SQ_STEPS-1][30:0];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          cry[g] <= cry[g-1];
        end
      end
    end
  end

  assign empty       = !vld[NST-1];
  assign out_x       = oq[0];
  assign out_y       = oq[1];
  assign out_z       = oq[2];
  assign out_w       = oq[3];
  assign used_linear = cry[NST-1].lin;
  assign end_negated = cry[NST-1].neg;

endmodule

@@ sim/quaternion_slerp_core_tb.sv @@
`timescale 1ns / 100ps

module quaternion_slerp_core_tb;
  import qslerp_pkg::*;

  localparam int LATENCY   = 117;
  localparam int WD_LIMIT  = 4000;
  localparam int N_RANDOM  = 600;

  typedef struct {
    logic [15:0] s [4];
    logic [15:0] e [4];
    logic [16:0] t;
  } slerp_req_t;

  typedef struct {
    logic [15:0] q [4];
    logic        lin;
    logic        neg;
  } slerp_res_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  q15_t        start_x, start_y, start_z, start_w;
  q15_t        end_x, end_y, end_z, end_w;
  logic [16:0] fraction;
  logic        empty;
  logic        pop;
  q15_t        out_x, out_y, out_z, out_w;
  logic        used_linear;
  logic        end_negated;
  logic        cfg_we;
  logic [14:0] cfg_wdata;

  slerp_req_t  pending_reqs [$];
  slerp_res_t  expected_res [$];
  logic [14:0] thresh;
  int          errors;
  int          idle_cycles;
  int          hold_off;
  int          send_gap;
  int          recv_gap;

  quaternion_slerp_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .start_x(start_x), .start_y(start_y), .start_z(start_z), .start_w(start_w),
    .end_x(end_x), .end_y(end_y), .end_z(end_z), .end_w(end_w),
    .fraction(fraction), .empty(empty), .pop(pop),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .used_linear(used_linear), .end_negated(end_negated),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // arctan table, scale 2^30 rad
  function automatic longint atan_entry(int i);
    longint tbl [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  // arithmetic shift rounds toward minus infinity
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // CORDIC vectoring: angle of (x, y)
  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    return z;
  endfunction

  // CORDIC rotation: sine at scale 2^30
  function automatic longint cordic_sine(longint a);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_entry(i);
      end else begin
        x += dx; y -= dy; a += atan_entry(i);
      end
    end
    return y;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic slerp_res_t predict_slerp(slerp_req_t r, logic [14:0] th);
    slerp_res_t res;
    longint s [4], e [4];
    longint dot, t, sn, theta, a0, a1, w0, w1, comp, num;
    dot = 0;
    t = (r.t > 65536) ? 65536 : r.t;
    for (int k = 0; k < 4; k++) begin
      s[k] = $signed(r.s[k]);
      e[k] = $signed(r.e[k]);
      dot += s[k] * e[k];
    end
    res.neg = (dot < 0);
    if (dot < 0) begin
      dot = -dot;
      for (int k = 0; k < 4; k++) e[k] = -e[k];
    end
    res.lin = dot > (longint'(th) << 15);
    if (res.lin) begin
      for (int k = 0; k < 4; k++) begin
        comp = s[k] * (65536 - t) + e[k] * t;
        res.q[k] = clamp16(fshr(comp + 32768, 16));
      end
    end else begin
      sn = int_sqrt((64'd1 << 60) - longint'(dot * dot));
      theta = cordic_angle(dot, sn);
      a1 = (theta * t) >>> 16;
      a0 = (theta * (65536 - t)) >>> 16;
      w0 = cordic_sine(a0);
      w1 = cordic_sine(a1);
      if (sn <= 0) sn = 1;
      for (int k = 0; k < 4; k++) begin
        num = s[k] * w0 + e[k] * w1;
        res.q[k] = clamp16(round_div(num, sn));
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic slerp_req_t make_req(longint sx, longint sy, longint sz, longint sw,
                                          longint ex, longint ey, longint ez, longint ew,
                                          longint t);
    slerp_req_t r;
    r.s[0] = 16'(sx); r.s[1] = 16'(sy); r.s[2] = 16'(sz); r.s[3] = 16'(sw);
    r.e[0] = 16'(ex); r.e[1] = 16'(ey); r.e[2] = 16'(ez); r.e[3] = 16'(ew);
    r.t = 17'(t);
    return r;
  endfunction

  // random unit-ish quaternion, or raw noise
  function automatic slerp_req_t rand_req();
    slerp_req_t r;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      r.s[k] = 16'($urandom);
      r.e[k] = 16'($urandom);
    end
    if (mode < 4) begin
      // near-parallel pair, small perturbation, sign flipped at random
      for (int k = 0; k < 4; k++) begin
        r.s[k] = $signed(r.s[k]) >>> 1;
        r.e[k] = 16'($signed(r.s[k]) + int'($urandom_range(0, 2000)) - 1000);
        if (mode == 1) r.e[k] = -$signed(r.e[k]);
      end
    end else if (mode < 8) begin
      // roughly unit magnitudes: scale down to keep norms near one
      for (int k = 0; k < 4; k++) begin
        r.s[k] = $signed(r.s[k]) >>> 1;
        r.e[k] = $signed(r.e[k]) >>> 1;
      end
    end
    case ($urandom_range(0, 7))
      0: r.t = 17'd0;
      1: r.t = 17'd65536;
      2: r.t = 17'($urandom_range(65537, 131071));
      default: r.t = 17'($urandom_range(0, 65536));
    endcase
    return r;
  endfunction

  // wait until every queued request has been sent and answered
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_thresh(logic [14:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    thresh <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // put the request at the head of the pending queue on the ports
  task automatic drive_head();
    push <= 1'b1;
    start_x <= pending_reqs[0].s[0];
    start_y <= pending_reqs[0].s[1];
    start_z <= pending_reqs[0].s[2];
    start_w <= pending_reqs[0].s[3];
    end_x <= pending_reqs[0].e[0];
    end_y <= pending_reqs[0].e[1];
    end_z <= pending_reqs[0].e[2];
    end_w <= pending_reqs[0].e[3];
    fraction <= pending_reqs[0].t;
  endtask

  // stimulus
  initial begin
    logic [14:0] settings [4];
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    {start_x, start_y, start_z, start_w} = '0;
    {end_x, end_y, end_z, end_w} = '0;
    fraction = '0;
    thresh = THRESH_RESET;
    errors = 0;
    hold_off = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed requests at reset threshold
    pending_reqs.push_back(make_req(32767, 0, 0, 0, 32767, 0, 0, 0, 32768));
    pending_reqs.push_back(make_req(32767, 0, 0, 0, 0, 32767, 0, 0, 32768));
    pending_reqs.push_back(make_req(32767, 0, 0, 0, 0, 32767, 0, 0, 0));
    pending_reqs.push_back(make_req(32767, 0, 0, 0, 0, 32767, 0, 0, 65536));
    pending_reqs.push_back(make_req(32767, 0, 0, 0, 0, 32767, 0, 0, 131071));
    pending_reqs.push_back(make_req(23170, 23170, 0, 0, -23170, 0, -23170, 0, 20000));
    pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768, 40000));
    pending_reqs.push_back(make_req(32767, 32767, 32767, 32767,
                                    -32768, -32768, -32768, -32768, 30000));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 12345));
    pending_reqs.push_back(make_req(16384, 16384, 16384, 16384,
                                    16384, -16384, 16384, 16384, 50000));
    pending_reqs.push_back(make_req(32767, 0, 0, 0, 32700, 2000, 0, 0, 32768));
    pending_reqs.push_back(make_req(32767, -32768, 1, -1, -32768, 32767, -1, 1, 65535));
    drain();

    settings = '{15'd0, 15'd32767, 15'd16384, THRESH_RESET};
    for (int p = 0; p < 4; p++) begin
      write_thresh(settings[p]);
      pending_reqs.push_back(make_req(32767, 0, 0, 0, 23170, 23170, 0, 0, 32768));
      for (int n = 0; n < N_RANDOM / 4; n++) pending_reqs.push_back(rand_req());
      // long receive stall while a full phase is still queued, so the block fills
      if (p == 1) begin
        hold_off = 600;
      end
      drain();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      push <= 1'b0;
      send_gap <= 0;
    end else if (push && !full) begin
      // request taken; next one after a random gap
      pending_reqs.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (gap == 0 && pending_reqs.size() > 0) begin
        drive_head();
        send_gap <= 0;
      end else begin
        push <= 1'b0;
        send_gap <= (gap > 0) ? gap - 1 : 0;
      end
    end else if (!push && send_gap > 0) begin
      send_gap <= send_gap - 1;
    end else if (!push && pending_reqs.size() > 0) begin
      drive_head();
    end
  end

  // prediction on each accepted request
  always @(posedge clk) begin
    slerp_req_t r;
    if (!rst && push && !full) begin
      r = make_req(start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w,
                   fraction);
      expected_res.push_back(predict_slerp(r, thresh));
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    slerp_res_t want;
    int gap;
    if (rst) begin
      pop <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_res.pop_front();
          if (out_x !== want.q[0]) report_mismatch("out_x", out_x, $signed(want.q[0]));
          if (out_y !== want.q[1]) report_mismatch("out_y", out_y, $signed(want.q[1]));
          if (out_z !== want.q[2]) report_mismatch("out_z", out_z, $signed(want.q[2]));
          if (out_w !== want.q[3]) report_mismatch("out_w", out_w, $signed(want.q[3]));
          if (used_linear !== want.lin) report_mismatch("used_linear", used_linear, want.lin);
          if (end_negated !== want.neg) report_mismatch("end_negated", end_negated, want.neg);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else if (pop && !empty) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        pop <= (gap == 0);
        recv_gap <= (gap > 0) ? gap - 1 : 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake while work is outstanding
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) ||
        (expected_res.size() == 0 && pending_reqs.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
rtl/qslerp_pkg.sv
rtl/qslerp_fifo.sv
rtl/qslerp_front.sv
rtl/qslerp_back.sv
rtl/quaternion_slerp_core.sv
sim/quaternion_slerp_core_tb.sv
